// File: sv/msd_pkg.sv
package msd_pkg;

    localparam logic [7:0] CH_DOT   = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // dashes are three '=' in a row
    localparam logic [1:0] EQ_PER_DASH = 2'd3;
    localparam logic [2:0] MAX_SYMBOLS = 3'd5;

    localparam logic [1:0] SP_NONE = 2'd0;
    localparam logic [1:0] SP_ONE  = 2'd1;
    localparam logic [1:0] SP_RUN  = 2'd2;

    // result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_LETTER = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_END    = 2'd2,
        KIND_ERROR  = 2'd3
    } t_rkind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_CHAR = 3'd1,
        ERR_BROKEN   = 3'd2,
        ERR_UNKNOWN  = 3'd3,
        ERR_EMPTY    = 3'd4
    } t_err;

    typedef struct packed {
        t_rkind     kind;
        logic [7:0] character;
        t_err       error_code;
        logic       last;
    } t_result;

    typedef struct packed {
        logic       found;
        logic [7:0] ch;
    } t_lookup;

    typedef struct packed {
        logic    hit;
        logic    is_err;
        t_result res;
    } t_flush;

    function automatic t_result f_make(t_rkind kind, logic [7:0] ch, t_err err,
                                       logic last);
        t_result r;
        r.kind       = kind;
        r.character  = ch;
        r.error_code = err;
        r.last       = last;
        return r;
    endfunction

    // symbol count and bits (first symbol msb, dash = 1) to ASCII
    function automatic t_lookup f_lookup(logic [2:0] len, logic [4:0] bits);
        t_lookup l;
        l.found = 1'b1;
        case ({len, bits})
            {3'd2, 5'd1}:  l.ch = "A";
            {3'd4, 5'd8}:  l.ch = "B";
            {3'd4, 5'd10}: l.ch = "C";
            {3'd3, 5'd4}:  l.ch = "D";
            {3'd1, 5'd0}:  l.ch = "E";
            {3'd4, 5'd2}:  l.ch = "F";
            {3'd3, 5'd6}:  l.ch = "G";
            {3'd4, 5'd0}:  l.ch = "H";
            {3'd2, 5'd0}:  l.ch = "I";
            {3'd4, 5'd7}:  l.ch = "J";
            {3'd3, 5'd5}:  l.ch = "K";
            {3'd4, 5'd4}:  l.ch = "L";
            {3'd2, 5'd3}:  l.ch = "M";
            {3'd2, 5'd2}:  l.ch = "N";
            {3'd3, 5'd7}:  l.ch = "O";
            {3'd4, 5'd6}:  l.ch = "P";
            {3'd4, 5'd13}: l.ch = "Q";
            {3'd3, 5'd2}:  l.ch = "R";
            {3'd3, 5'd0}:  l.ch = "S";
            {3'd1, 5'd1}:  l.ch = "T";
            {3'd3, 5'd1}:  l.ch = "U";
            {3'd4, 5'd1}:  l.ch = "V";
            {3'd3, 5'd3}:  l.ch = "W";
            {3'd4, 5'd9}:  l.ch = "X";
            {3'd4, 5'd11}: l.ch = "Y";
            {3'd4, 5'd12}: l.ch = "Z";
            {3'd5, 5'd31}: l.ch = "0";
            {3'd5, 5'd15}: l.ch = "1";
            {3'd5, 5'd7}:  l.ch = "2";
            {3'd5, 5'd3}:  l.ch = "3";
            {3'd5, 5'd1}:  l.ch = "4";
            {3'd5, 5'd0}:  l.ch = "5";
            {3'd5, 5'd16}: l.ch = "6";
            {3'd5, 5'd24}: l.ch = "7";
            {3'd5, 5'd28}: l.ch = "8";
            {3'd5, 5'd30}: l.ch = "9";
            default: begin
                l.found = 1'b0;
                l.ch    = 8'h00;
            end
        endcase
        return l;
    endfunction

    // close the current token: letter, error, or nothing if empty
    function automatic t_flush f_flush(logic [1:0] eq, logic [2:0] len,
                                       logic [4:0] bits);
        t_flush  f;
        t_lookup l;
        l        = f_lookup(len, bits);
        f.hit    = 1'b0;
        f.is_err = 1'b0;
        f.res    = f_make(KIND_LETTER, 8'h00, ERR_NONE, 1'b0);
        if (eq != 2'd0) begin
            f.hit    = 1'b1;
            f.is_err = 1'b1;
            f.res    = f_make(KIND_ERROR, 8'h00, ERR_BROKEN, 1'b0);
        end else if (len != 3'd0) begin
            f.hit = 1'b1;
            if (l.found) begin
                f.res = f_make(KIND_LETTER, l.ch, ERR_NONE, 1'b0);
            end else begin
                f.is_err = 1'b1;
                f.res    = f_make(KIND_ERROR, 8'h00, ERR_UNKNOWN, 1'b0);
            end
        end
        return f;
    endfunction

endpackage

// File: sv/msd_result_queue.sv
module msd_result_queue import msd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_push_count,
    input  t_result     i_push_first,
    input  t_result     i_push_second,
    input  logic        i_pop,
    output t_result     o_head,
    output logic        o_not_empty,
    output logic        o_room_for_two
);

    t_result             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                pop_ok;

    assign pop_ok         = i_pop && (r_count != '0);
    assign o_head         = r_mem[r_rd_ptr];
    assign o_not_empty    = (r_count != '0);
    assign o_room_for_two = (r_count <= QCNT_W'(QDEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_push_count);
        n_rd_ptr = r_rd_ptr + QPTR_W'(pop_ok);
        n_count  = r_count + QCNT_W'(i_push_count) - QCNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push_first;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_push_second;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

endmodule

// File: sv/morse_symbol_stream_decoder.sv
// Morse symbol stream decoder.
// Input channel (i_valid / o_ready): one item per handshake, i_kind = 0 carries a
// message byte in i_symbol ('+' dot, '=' dash part, space separator), i_kind = 1
// marks end of message. Output channel (o_valid / i_ready): one result item per
// handshake: a letter, a word space, end of message (o_last = 1) or an error code.
// Each accepted item is decoded in the cycle it is taken; its zero, one or two
// results land in a four-entry result queue, so the first result is offered on
// the output from the next cycle at the earliest.
// Throughput: one input item per cycle while o_ready is high. Only an end of
// message that closes a pending token gives two results (the letter or error,
// then the end result); the queue takes both in one push.
// o_ready is high while the queue has room for two results, so a stalled
// receiver backs the input up once more than two results wait; nothing is dropped.
// Reset clears the token state and empties the queue; no results are pending.
// After an error, characters are swallowed until end of message.
module morse_symbol_stream_decoder import msd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_symbol,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_character,
    output logic [2:0] o_error_code,
    output logic       o_last
);

    // token state
    logic [4:0] r_code_bits,   n_code_bits;
    logic [2:0] r_code_length, n_code_length;
    logic [1:0] r_equals_run,  n_equals_run;
    logic [1:0] r_space_run,   n_space_run;
    logic       r_seen_any,    n_seen_any;
    logic       r_error_hold,  n_error_hold;

    logic       accept;
    t_flush     fl;
    logic [1:0] eq_inc;
    logic       do_append;
    logic       append_bit;
    logic [1:0] push_count;
    t_result    res_first, res_second;
    t_result    head;
    logic       room_for_two;

    assign accept  = i_valid && o_ready;
    assign o_ready = room_for_two;

    always_comb begin
        n_code_bits   = r_code_bits;
        n_code_length = r_code_length;
        n_equals_run  = r_equals_run;
        n_space_run   = r_space_run;
        n_seen_any    = r_seen_any;
        n_error_hold  = r_error_hold;
        push_count    = 2'd0;
        res_first     = f_make(KIND_END, 8'h00, ERR_NONE, 1'b1);
        res_second    = f_make(KIND_END, 8'h00, ERR_NONE, 1'b1);
        do_append     = 1'b0;
        append_bit    = 1'b0;
        fl            = f_flush(r_equals_run, r_code_length, r_code_bits);
        eq_inc        = r_equals_run + 2'd1;

        if (accept) begin
            if (i_kind) begin
                if (!r_seen_any) begin
                    // empty message: lone error, no end result
                    res_first  = f_make(KIND_ERROR, 8'h00, ERR_EMPTY, 1'b1);
                    push_count = 2'd1;
                end else if (!r_error_hold && fl.hit) begin
                    res_first  = fl.res;
                    push_count = 2'd2;
                end else begin
                    push_count = 2'd1;
                end
                n_code_bits   = '0;
                n_code_length = '0;
                n_equals_run  = '0;
                n_space_run   = SP_NONE;
                n_seen_any    = 1'b0;
                n_error_hold  = 1'b0;
            end else if (!r_error_hold) begin
                n_seen_any = 1'b1;
                case (i_symbol)
                    CH_SPACE: begin
                        n_code_bits   = '0;
                        n_code_length = '0;
                        n_equals_run  = '0;
                        if (fl.hit) begin
                            res_first  = fl.res;
                            push_count = 2'd1;
                        end
                        if (fl.is_err) begin
                            n_error_hold = 1'b1;
                        end else if (r_space_run == SP_ONE) begin
                            // second space of a run: one word gap
                            if (fl.hit) begin
                                res_second = f_make(KIND_WORD, CH_SPACE, ERR_NONE, 1'b0);
                                push_count = 2'd2;
                            end else begin
                                res_first  = f_make(KIND_WORD, CH_SPACE, ERR_NONE, 1'b0);
                                push_count = 2'd1;
                            end
                            n_space_run = SP_RUN;
                        end else if (r_space_run == SP_NONE) begin
                            n_space_run = SP_ONE;
                        end
                    end
                    CH_DOT: begin
                        n_space_run = SP_NONE;
                        if (r_equals_run != 2'd0) begin
                            n_code_bits   = '0;
                            n_code_length = '0;
                            n_equals_run  = '0;
                            n_error_hold  = 1'b1;
                            res_first     = f_make(KIND_ERROR, 8'h00, ERR_BROKEN, 1'b0);
                            push_count    = 2'd1;
                        end else begin
                            do_append  = 1'b1;
                            append_bit = 1'b0;
                        end
                    end
                    CH_EQ: begin
                        n_space_run = SP_NONE;
                        if (eq_inc == EQ_PER_DASH) begin
                            n_equals_run = '0;
                            do_append    = 1'b1;
                            append_bit   = 1'b1;
                        end else begin
                            n_equals_run = eq_inc;
                        end
                    end
                    default: begin
                        n_code_bits   = '0;
                        n_code_length = '0;
                        n_equals_run  = '0;
                        n_error_hold  = 1'b1;
                        res_first     = f_make(KIND_ERROR, 8'h00, ERR_BAD_CHAR, 1'b0);
                        push_count    = 2'd1;
                    end
                endcase

                if (do_append) begin
                    if (r_code_length >= MAX_SYMBOLS) begin
                        // sixth symbol: token can never match
                        n_code_bits   = '0;
                        n_code_length = '0;
                        n_equals_run  = '0;
                        n_error_hold  = 1'b1;
                        res_first     = f_make(KIND_ERROR, 8'h00, ERR_UNKNOWN, 1'b0);
                        push_count    = 2'd1;
                    end else begin
                        n_code_bits   = {r_code_bits[3:0], append_bit};
                        n_code_length = r_code_length + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits   <= '0;
            r_code_length <= '0;
            r_equals_run  <= '0;
            r_space_run   <= SP_NONE;
            r_seen_any    <= 1'b0;
            r_error_hold  <= 1'b0;
        end else begin
            r_code_bits   <= n_code_bits;
            r_code_length <= n_code_length;
            r_equals_run  <= n_equals_run;
            r_space_run   <= n_space_run;
            r_seen_any    <= n_seen_any;
            r_error_hold  <= n_error_hold;
        end
    end

    // results wait here for the receiver
    msd_result_queue u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push_count   (push_count),
        .i_push_first   (res_first),
        .i_push_second  (res_second),
        .i_pop          (i_ready),
        .o_head         (head),
        .o_not_empty    (o_valid),
        .o_room_for_two (room_for_two)
    );

    assign o_result_kind = head.kind;
    assign o_character   = head.character;
    assign o_error_code  = head.error_code;
    assign o_last        = head.last;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind) |=> (r_code_length == 3'd0 && r_equals_run == 2'd0 &&
                                !r_seen_any && !r_error_hold))
        else $error("state not cleared after end of message");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_code_length <= MAX_SYMBOLS)
        else $error("token longer than five symbols");

    a_eq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_equals_run != EQ_PER_DASH)
        else $error("complete dash left pending");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error_hold |-> (r_code_length == 3'd0 && r_equals_run == 2'd0))
        else $error("token state live after error");

endmodule

// File: tb/testbench.sv
module testbench;
    import msd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ---------------------------------------------------------------
    // Signals: every input of the block starts at a known value
    // ---------------------------------------------------------------
    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       i_valid  = 1'b0;
    logic       i_kind   = 1'b0;
    logic [7:0] i_symbol = 8'h00;
    logic       i_ready  = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_result_kind;
    logic [7:0] o_character;
    logic [2:0] o_error_code;
    logic       o_last;

    morse_symbol_stream_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_symbol      (i_symbol),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_character   (o_character),
        .o_error_code  (o_error_code),
        .o_last        (o_last)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("morse_symbol_stream_decoder: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Letter table: {symbol count, symbol bits (first symbol msb,
    // dash = 1), ASCII}
    // ---------------------------------------------------------------
    localparam logic [15:0] MORSE_TABLE [36] = '{
        {3'd2, 5'd1,  "A"}, {3'd4, 5'd8,  "B"}, {3'd4, 5'd10, "C"},
        {3'd3, 5'd4,  "D"}, {3'd1, 5'd0,  "E"}, {3'd4, 5'd2,  "F"},
        {3'd3, 5'd6,  "G"}, {3'd4, 5'd0,  "H"}, {3'd2, 5'd0,  "I"},
        {3'd4, 5'd7,  "J"}, {3'd3, 5'd5,  "K"}, {3'd4, 5'd4,  "L"},
        {3'd2, 5'd3,  "M"}, {3'd2, 5'd2,  "N"}, {3'd3, 5'd7,  "O"},
        {3'd4, 5'd6,  "P"}, {3'd4, 5'd13, "Q"}, {3'd3, 5'd2,  "R"},
        {3'd3, 5'd0,  "S"}, {3'd1, 5'd1,  "T"}, {3'd3, 5'd1,  "U"},
        {3'd4, 5'd1,  "V"}, {3'd3, 5'd3,  "W"}, {3'd4, 5'd9,  "X"},
        {3'd4, 5'd11, "Y"}, {3'd4, 5'd12, "Z"}, {3'd5, 5'd31, "0"},
        {3'd5, 5'd15, "1"}, {3'd5, 5'd7,  "2"}, {3'd5, 5'd3,  "3"},
        {3'd5, 5'd1,  "4"}, {3'd5, 5'd0,  "5"}, {3'd5, 5'd16, "6"},
        {3'd5, 5'd24, "7"}, {3'd5, 5'd28, "8"}, {3'd5, 5'd30, "9"}
    };

    // One stimulus row: item plus, optionally, the results typed in by hand
    typedef struct packed {
        logic       kind;
        logic [7:0] symbol;
        logic       typed;
        logic [1:0] n_typed;
        t_result    r0;
        t_result    r1;
    } t_row;

    // ---------------------------------------------------------------
    // Decoder shadow state
    // ---------------------------------------------------------------
    logic [4:0] tok_bits;
    logic [2:0] tok_len;
    logic [1:0] eq_count;
    logic [1:0] gap_run;
    logic       msg_started;
    logic       msg_failed;

    t_result    step_out [$];          // results of the item just taken
    t_result    awaited_results [$];   // results not yet seen on the output
    logic [7:0] msg_bytes [$];         // characters of the message being built

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int failures           = 0;
    int items_decoded      = 0;
    int items_swallowed    = 0;
    int messages_sent      = 0;
    int results_checked    = 0;

    t_row directed_rows [25];

    function automatic t_result result_of(t_rkind k, logic [7:0] c, t_err e, logic l);
        t_result r;
        r.kind       = k;
        r.character  = c;
        r.error_code = e;
        r.last       = l;
        return r;
    endfunction

    function automatic t_row row(logic k, logic [7:0] s);
        t_row r;
        r.kind    = k;
        r.symbol  = s;
        r.typed   = 1'b0;
        r.n_typed = 2'd0;
        r.r0      = result_of(KIND_LETTER, 8'h00, ERR_NONE, 1'b0);
        r.r1      = r.r0;
        return r;
    endfunction

    function automatic t_row typed_row(logic k, logic [7:0] s, logic [1:0] n,
                                       t_result a, t_result b);
        t_row r;
        r         = row(k, s);
        r.typed   = 1'b1;
        r.n_typed = n;
        r.r0      = a;
        r.r1      = b;
        return r;
    endfunction

    function automatic void clear_state();
        tok_bits    = 5'd0;
        tok_len     = 3'd0;
        eq_count    = 2'd0;
        gap_run     = SP_NONE;
        msg_started = 1'b0;
        msg_failed  = 1'b0;
    endfunction

    function automatic void clear_token();
        tok_bits = 5'd0;
        tok_len  = 3'd0;
        eq_count = 2'd0;
    endfunction

    function automatic void raise_fault(t_err code);
        step_out.push_back(result_of(KIND_ERROR, 8'h00, code, 1'b0));
        msg_failed = 1'b1;
    endfunction

    // finish the current token: letter, error, or nothing when empty
    function automatic void close_token();
        logic       found;
        logic [7:0] ch;
        found = 1'b0;
        ch    = 8'h00;
        if (eq_count != 2'd0) begin
            clear_token();
            raise_fault(ERR_BROKEN);
        end else if (tok_len != 3'd0) begin
            for (int i = 0; i < 36; i++) begin
                if (MORSE_TABLE[i][15:13] == tok_len && MORSE_TABLE[i][12:8] == tok_bits) begin
                    found = 1'b1;
                    ch    = MORSE_TABLE[i][7:0];
                end
            end
            clear_token();
            if (found) begin
                step_out.push_back(result_of(KIND_LETTER, ch, ERR_NONE, 1'b0));
            end else begin
                raise_fault(ERR_UNKNOWN);
            end
        end
    endfunction

    function automatic void add_symbol(logic dash);
        if (tok_len >= 3'd5) begin
            // sixth symbol: no letter can match, fault straight away
            clear_token();
            raise_fault(ERR_UNKNOWN);
        end else begin
            tok_bits = {tok_bits[3:0], dash};
            tok_len  = tok_len + 3'd1;
        end
    endfunction

    // Works out the results of one item; returns 1 if the item is swallowed
    function automatic bit predict_item(logic kind, logic [7:0] sym);
        step_out.delete();
        if (kind) begin
            if (!msg_started) begin
                step_out.push_back(result_of(KIND_ERROR, 8'h00, ERR_EMPTY, 1'b1));
            end else begin
                if (!msg_failed) close_token();
                step_out.push_back(result_of(KIND_END, 8'h00, ERR_NONE, 1'b1));
            end
            clear_state();
            return 1'b0;
        end
        if (msg_failed) return 1'b1;
        msg_started = 1'b1;
        if (sym == CH_SPACE) begin
            close_token();
            if (!msg_failed) begin
                // second space of a run gives the word space, later ones nothing
                if (gap_run == SP_ONE) begin
                    step_out.push_back(result_of(KIND_WORD, CH_SPACE, ERR_NONE, 1'b0));
                    gap_run = SP_RUN;
                end else if (gap_run == SP_NONE) begin
                    gap_run = SP_ONE;
                end
            end
        end else if (sym == CH_DOT) begin
            gap_run = SP_NONE;
            if (eq_count != 2'd0) begin
                clear_token();
                raise_fault(ERR_BROKEN);
            end else begin
                add_symbol(1'b0);
            end
        end else if (sym == CH_EQ) begin
            gap_run  = SP_NONE;
            eq_count = eq_count + 2'd1;
            if (eq_count >= 2'd3) begin
                eq_count = 2'd0;
                add_symbol(1'b1);
            end
        end else begin
            clear_token();
            raise_fault(ERR_BAD_CHAR);
        end
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // Sender: optional idle cycles, then hold the item until taken.
    // Valid is only lowered when an idle cycle follows, so it is never
    // dropped and raised in one step.
    // ---------------------------------------------------------------
    task automatic send_item(input t_row item);
        bit dropped;
        if (sender_idle_pct != 0) begin
            while ($urandom_range(99) < sender_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid  <= 1'b1;
        i_kind   <= item.kind;
        i_symbol <= item.symbol;
        do @(posedge i_clk); while (!o_ready);
        dropped = predict_item(item.kind, item.symbol);
        if (dropped) items_swallowed++;
        else items_decoded++;
        if (item.kind) messages_sent++;
        if (item.typed) begin
            if (item.n_typed > 2'd0) awaited_results.push_back(item.r0);
            if (item.n_typed > 2'd1) awaited_results.push_back(item.r1);
        end else begin
            foreach (step_out[j]) awaited_results.push_back(step_out[j]);
        end
    endtask

    // Mostly well-formed messages with random letters, spaces and lengths;
    // some empty, some pure noise, some with broken runs or stray bytes.
    task automatic compose_message();
        int n_tok;
        int n_sym;
        int roll;
        msg_bytes.delete();
        roll = $urandom_range(99);
        if (roll < 4) return;
        if (roll < 10) begin
            repeat ($urandom_range(6, 1)) msg_bytes.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 1)) msg_bytes.push_back(CH_SPACE);
        end
        n_tok = $urandom_range(5, 1);
        for (int t = 0; t < n_tok; t++) begin
            // occasional six-symbol token
            n_sym = ($urandom_range(24) == 0) ? 6 : $urandom_range(5, 1);
            for (int s = 0; s < n_sym; s++) begin
                if ($urandom_range(1)) begin
                    repeat (3) msg_bytes.push_back(CH_EQ);
                end else begin
                    msg_bytes.push_back(CH_DOT);
                end
            end
            if ($urandom_range(29) == 0) begin
                repeat ($urandom_range(2, 1)) msg_bytes.push_back(CH_EQ);
            end
            if (t < n_tok - 1 || $urandom_range(3) == 0) begin
                roll = $urandom_range(9);
                repeat (roll < 6 ? 1 : (roll < 9 ? 2 : 3)) msg_bytes.push_back(CH_SPACE);
            end
        end
        if ($urandom_range(14) == 0) begin
            msg_bytes.insert($urandom_range(msg_bytes.size()), 8'($urandom));
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver and result checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: kind %0d char %0d err %0d last %0d",
                       o_result_kind, o_character, o_error_code, o_last);
                failures++;
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (o_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, o_result_kind);
                    failures++;
                end
                if (o_character !== want.character) begin
                    $error("character: expected %0d, got %0d", want.character, o_character);
                    failures++;
                end
                if (o_error_code !== want.error_code) begin
                    $error("error_code: expected %0d, got %0d", want.error_code, o_error_code);
                    failures++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    failures++;
                end
            end
        end
        i_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int phase_count;
        clear_state();

        // directed: extremes, each fault, end of message closing a token
        directed_rows = '{
            // end straight after reset: empty message
            typed_row(1'b1, 8'h00, 2'd1,
                      result_of(KIND_ERROR, 8'h00, ERR_EMPTY, 1'b1),
                      result_of(KIND_LETTER, 8'h00, ERR_NONE, 1'b0)),
            // byte 0 is a bad character, then 0xFF is swallowed
            typed_row(1'b0, 8'h00, 2'd1,
                      result_of(KIND_ERROR, 8'h00, ERR_BAD_CHAR, 1'b0),
                      result_of(KIND_LETTER, 8'h00, ERR_NONE, 1'b0)),
            typed_row(1'b0, 8'hFF, 2'd0,
                      result_of(KIND_LETTER, 8'h00, ERR_NONE, 1'b0),
                      result_of(KIND_LETTER, 8'h00, ERR_NONE, 1'b0)),
            typed_row(1'b1, 8'hFF, 2'd1,
                      result_of(KIND_END, 8'h00, ERR_NONE, 1'b1),
                      result_of(KIND_LETTER, 8'h00, ERR_NONE, 1'b0)),
            // dot then space; dash closed by end of message
            row(1'b0, CH_DOT), row(1'b0, CH_SPACE),
            row(1'b0, CH_EQ), row(1'b0, CH_EQ), row(1'b0, CH_EQ),
            row(1'b1, 8'h00),
            // leading spaces: word space on the second, nothing on the third
            row(1'b0, CH_SPACE), row(1'b0, CH_SPACE), row(1'b0, CH_SPACE),
            // lone '=' closed by end of message
            row(1'b0, CH_EQ),
            typed_row(1'b1, 8'h00, 2'd2,
                      result_of(KIND_ERROR, 8'h00, ERR_BROKEN, 1'b0),
                      result_of(KIND_END, 8'h00, ERR_NONE, 1'b1)),
            // six dots in one token
            row(1'b0, CH_DOT), row(1'b0, CH_DOT), row(1'b0, CH_DOT),
            row(1'b0, CH_DOT), row(1'b0, CH_DOT),
            typed_row(1'b0, CH_DOT, 2'd1,
                      result_of(KIND_ERROR, 8'h00, ERR_UNKNOWN, 1'b0),
                      result_of(KIND_LETTER, 8'h00, ERR_NONE, 1'b0)),
            typed_row(1'b1, 8'h00, 2'd1,
                      result_of(KIND_END, 8'h00, ERR_NONE, 1'b1),
                      result_of(KIND_LETTER, 8'h00, ERR_NONE, 1'b0)),
            // dot inside a pending '=' run
            row(1'b0, CH_EQ),
            typed_row(1'b0, CH_DOT, 2'd1,
                      result_of(KIND_ERROR, 8'h00, ERR_BROKEN, 1'b0),
                      result_of(KIND_LETTER, 8'h00, ERR_NONE, 1'b0)),
            typed_row(1'b1, 8'h00, 2'd1,
                      result_of(KIND_END, 8'h00, ERR_NONE, 1'b1),
                      result_of(KIND_LETTER, 8'h00, ERR_NONE, 1'b0))
        };

        // hold reset, then release it once
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) send_item(directed_rows[i]);

        // random messages under four idling patterns
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 61;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 61;
                end
                default: begin
                    sender_idle_pct    = 11;
                    receiver_stall_pct = 11;
                end
            endcase
            phase_count = items_decoded;
            while (items_decoded - phase_count < 190) begin
                compose_message();
                foreach (msg_bytes[i]) send_item(row(1'b0, msg_bytes[i]));
                send_item(row(1'b1, 8'($urandom)));
            end
        end

        // drain, then wait quietly to catch stray results
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d items decoded, %0d swallowed after faults, %0d messages",
                 items_decoded, items_swallowed, messages_sent);
        $display("%0d results checked under four idling patterns", results_checked);
        if (failures == 0 && awaited_results.size() == 0) begin
            $display("morse_symbol_stream_decoder: match");
        end else begin
            $display("morse_symbol_stream_decoder: mismatch");
        end
        $finish;
    end

endmodule
